### hdl/scheduled_light_fade_controller_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef SCHEDULED_LIGHT_FADE_CONTROLLER_UNIT_ASSERT_SVH
`define SCHEDULED_LIGHT_FADE_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SLFC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbl failed");

// Next-cycle implication.
`define SLFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbl failed");

`endif

### hdl/slfc_pkg.sv
package slfc_pkg;

   localparam int SineIndexBitsDefault = 10;
   localparam int DurWidth = 22;
   localparam int QuotWidth = 16;
   localparam int StepWidth = 5;
   localparam longint unsigned HalfPiQ30 = 64'd1686629713;
   localparam logic [15:0] MsPerMinute = 16'd60000;
   localparam logic [10:0] MinutesPerDay = 11'd1440;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_ON       = 3'd1,
      CMD_OFF      = 3'd2,
      CMD_SET      = 3'd3,
      CMD_FADE_IN  = 3'd4,
      CMD_FADE_OUT = 3'd5,
      CMD_RST_STAT = 3'd6,
      CMD_NONE     = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OFF      = 2'd0,
      ST_ON       = 2'd1,
      ST_FADE_IN  = 2'd2,
      ST_FADE_OUT = 2'd3
   } light_type;

   typedef enum logic [2:0] {
      CSR_AUTO_MODE  = 3'd0,
      CSR_TEST_MODE  = 3'd1,
      CSR_MAX_BRIGHT = 3'd2,
      CSR_FADE_MIN   = 3'd3,
      CSR_ON_TIME    = 3'd4,
      CSR_SUNSET_EN  = 3'd5,
      CSR_SUNSET_OFS = 3'd6,
      CSR_OFF_HOUR   = 3'd7
   } csr_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_DIVP,
      SEQ_ROM,
      SEQ_MIX,
      SEQ_SCHED,
      SEQ_PCT,
      SEQ_DIVC,
      SEQ_OUT
   } seq_type;

   typedef struct packed {
      logic                   start;
      logic [DurWidth-1:0]    rem;
      logic [QuotWidth-1:0]   bits;
      logic [StepWidth-1:0]   steps;
   } div_cmd_type;

   function automatic longint unsigned taylor_div(input int k);
      case (k)
         1: return 64'd6;
         2: return 64'd20;
         3: return 64'd42;
         4: return 64'd72;
         5: return 64'd110;
         6: return 64'd156;
         default: return 64'd210;
      endcase
   endfunction

   // restoring long division, elaboration only
   function automatic longint unsigned const_udiv(input longint unsigned num,
                                                  input longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= den) begin
            r = r - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Quarter-sine entry in Q0.16, evaluated at elaboration only.
   function automatic logic [15:0] sine_entry(input int idx, input int index_bits);
      longint unsigned x;
      longint unsigned term;
      longint sum;
      longint unsigned r;
      x = (longint'(idx) * HalfPiQ30) >> index_bits;
      sum = longint'(x);
      term = x;
      for (int k = 1; k <= 7; k++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = const_udiv(term, taylor_div(k));
         if (k[0]) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (longint'(sum) + 64'd8192) >> 14;
      if (r > 64'd65535) r = 64'd65535;
      return r[15:0];
   endfunction

endpackage

### hdl/scheduled_light_fade_controller_unit.sv
// Sequence: an accepted item passes execute, percent and output; a tick (not in test mode)
// adds the schedule step, and while a fade is running the progress divide, table read and
// mix before it; a running fade adds the percent divide before output. A stalled output
// holds the item in the output state. One shared divider serves both divides.
// Throughput: a new item is taken only after the last one has left the output state.
// Reset: synchronous, active high; registers to defaults, light off, stats zero.
module scheduled_light_fade_controller_unit #(
   parameter int SINE_INDEX_BITS = slfc_pkg::SineIndexBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [31:0] req_now_ms,
   input  logic        req_time_valid,
   input  logic [10:0] req_day_minute,
   input  logic [10:0] req_sunset_minute,
   input  logic [6:0]  req_level_request,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_level,
   output logic [7:0]  rsp_pwm_duty,
   output logic [1:0]  rsp_light_state,
   output logic [6:0]  rsp_fade_percent,
   output logic [31:0] rsp_cycle_count,
   output logic [31:0] rsp_fade_in_total_ms,
   output logic [31:0] rsp_fade_out_total_ms,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_wdata
);
   import slfc_pkg::*;

   // config
   logic        auto_ff, test_ff, sun_en_ff;
   logic [6:0]  max_ff;
   logic [5:0]  fmin_ff;
   logic [10:0] on_time_ff, sun_ofs_ff;
   logic [4:0]  off_hour_ff;

   // item
   cmd_type     cmd_ff;
   logic [31:0] now_ff;
   logic        tval_ff;
   logic [10:0] day_ff, sunset_ff;
   logic [6:0]  lreq_ff;

   // state
   seq_type     seq_ff, seq_in;
   light_type   mode_ff;
   logic [6:0]  level_ff, blevel_ff, goal_ff, pct_ff;
   logic [31:0] begin_ff, on_cnt_ff, in_sum_ff, out_sum_ff;

   // output register
   logic        rsp_valid_ff;
   logic [6:0]  o_level_ff, o_pct_ff;
   logic [7:0]  o_pwm_ff;
   logic [1:0]  o_state_ff;
   logic [31:0] o_cnt_ff, o_in_ff, o_out_ff;

   logic [DurWidth-1:0]  dur;
   logic [31:0]          elapsed;
   logic                 fading, running;
   logic [6:0]           max_lvl;
   logic [28:0]          pct_num;
   div_cmd_type          div_cmd;
   logic                 div_busy;
   logic [QuotWidth-1:0] div_q;
   logic [15:0]          shaped;
   logic signed [7:0]    delta;
   logic signed [24:0]   mix_prod;
   logic [6:0]           mix_level;
   logic [10:0]          off_at;
   logic signed [12:0]   sun_sum, on_at;
   logic signed [12:0]   cur_s;
   logic [14:0]          pwm_num;
   logic [27:0]          pwm_prod;
   logic                 out_free;

   assign dur = DurWidth'(fmin_ff * MsPerMinute);
   assign elapsed = now_ff - begin_ff;
   assign fading = (mode_ff == ST_FADE_IN) || (mode_ff == ST_FADE_OUT);
   assign running = fading && (elapsed < {{(32-DurWidth){1'b0}}, dur});
   assign max_lvl = (max_ff > 7'd100) ? 7'd100 : max_ff;
   assign pct_num = 29'(elapsed[DurWidth-1:0] * 7'd100);

   assign delta = $signed({1'b0, goal_ff}) - $signed({1'b0, blevel_ff});
   assign mix_prod = delta * $signed({1'b0, shaped});
   assign mix_level = 7'(blevel_ff + 7'(mix_prod >>> 16));

   assign off_at = 11'(off_hour_ff * 6'd60);
   assign sun_sum = $signed({2'b00, sunset_ff}) + $signed({{2{sun_ofs_ff[10]}}, sun_ofs_ff});
   assign cur_s = $signed({2'b00, day_ff});
   always_comb begin
      if (!sun_en_ff) on_at = $signed({2'b00, on_time_ff});
      else if (sun_sum < 0) on_at = sun_sum + $signed({2'b00, MinutesPerDay});
      else if (sun_sum >= $signed({2'b00, MinutesPerDay}))
         on_at = sun_sum - $signed({2'b00, MinutesPerDay});
      else on_at = sun_sum;
   end

   // floor(level*255/100) via reciprocal multiply
   assign pwm_num = 15'(level_ff * 8'd255);
   assign pwm_prod = 28'(pwm_num * 13'd5243);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   slfc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .divisor  (dur),
      .busy     (div_busy),
      .quotient (div_q)
   );

   slfc_sine_rom #(.SINE_INDEX_BITS(SINE_INDEX_BITS)) u_rom (
      .clock (clock),
      .addr  (div_q[QuotWidth-1 -: SINE_INDEX_BITS]),
      .data  (shaped)
   );

   // next state
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SEQ_IDLE:  if (req_valid) seq_in = SEQ_EXEC;
         SEQ_EXEC: begin
            if (cmd_ff == CMD_TICK && !test_ff) seq_in = running ? SEQ_DIVP : SEQ_SCHED;
            else seq_in = SEQ_PCT;
         end
         SEQ_DIVP:  if (!div_busy) seq_in = SEQ_ROM;
         SEQ_ROM:   seq_in = SEQ_MIX;
         SEQ_MIX:   seq_in = SEQ_SCHED;
         SEQ_SCHED: seq_in = SEQ_PCT;
         SEQ_PCT:   seq_in = running ? SEQ_DIVC : SEQ_OUT;
         SEQ_DIVC:  if (!div_busy) seq_in = SEQ_OUT;
         SEQ_OUT:   if (out_free) seq_in = SEQ_IDLE;
         default:   seq_in = SEQ_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = seq_ff != SEQ_IDLE;
      div_cmd = '0;
      case (seq_ff)
         SEQ_EXEC: begin
            div_cmd.start = cmd_ff == CMD_TICK && !test_ff && running;
            div_cmd.rem = elapsed[DurWidth-1:0];
            div_cmd.steps = StepWidth'(QuotWidth);
         end
         SEQ_PCT: begin
            div_cmd.start = running;
            div_cmd.rem = pct_num[28:7];
            div_cmd.bits = {pct_num[6:0], {(QuotWidth-7){1'b0}}};
            div_cmd.steps = StepWidth'(7);
         end
         default: div_cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_IDLE;
         auto_ff <= 1'b0;
         test_ff <= 1'b0;
         max_ff <= 7'd80;
         fmin_ff <= 6'd15;
         on_time_ff <= 11'd360;
         sun_en_ff <= 1'b0;
         sun_ofs_ff <= '0;
         off_hour_ff <= 5'd21;
         mode_ff <= ST_OFF;
         level_ff <= '0;
         begin_ff <= '0;
         blevel_ff <= '0;
         goal_ff <= '0;
         on_cnt_ff <= '0;
         in_sum_ff <= '0;
         out_sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         if (csr_we) begin
            case (csr_type'(csr_index))
               CSR_AUTO_MODE:  auto_ff <= csr_wdata[0];
               CSR_TEST_MODE:  test_ff <= csr_wdata[0];
               CSR_MAX_BRIGHT: max_ff <= csr_wdata[6:0];
               CSR_FADE_MIN:   fmin_ff <= csr_wdata[5:0];
               CSR_ON_TIME:    on_time_ff <= csr_wdata;
               CSR_SUNSET_EN:  sun_en_ff <= csr_wdata[0];
               CSR_SUNSET_OFS: sun_ofs_ff <= csr_wdata;
               CSR_OFF_HOUR:   off_hour_ff <= csr_wdata[4:0];
               default: ;
            endcase
         end
         // held while stalled, set when the output stage loads an item
         rsp_valid_ff <= (seq_ff == SEQ_OUT && out_free) || (rsp_valid_ff && rsp_stall);
         case (seq_ff)
            SEQ_EXEC: begin
               case (cmd_ff)
                  CMD_TICK: begin
                     if (!test_ff && fading && !running) begin
                        level_ff <= goal_ff;
                        if (mode_ff == ST_FADE_IN) begin
                           mode_ff <= ST_ON;
                           on_cnt_ff <= on_cnt_ff + 1'b1;
                           in_sum_ff <= in_sum_ff + elapsed;
                        end else begin
                           mode_ff <= ST_OFF;
                           out_sum_ff <= out_sum_ff + elapsed;
                        end
                     end
                  end
                  CMD_ON: begin
                     level_ff <= max_lvl;
                     mode_ff <= ST_ON;
                     if (mode_ff != ST_ON) on_cnt_ff <= on_cnt_ff + 1'b1;
                  end
                  CMD_OFF: begin
                     level_ff <= '0;
                     mode_ff <= ST_OFF;
                  end
                  CMD_SET: level_ff <= (lreq_ff > 7'd100) ? 7'd100 : lreq_ff;
                  CMD_FADE_IN: begin
                     begin_ff <= now_ff;
                     blevel_ff <= level_ff;
                     goal_ff <= max_lvl;
                     mode_ff <= ST_FADE_IN;
                  end
                  CMD_FADE_OUT: begin
                     begin_ff <= now_ff;
                     blevel_ff <= level_ff;
                     goal_ff <= '0;
                     mode_ff <= ST_FADE_OUT;
                  end
                  CMD_RST_STAT: begin
                     on_cnt_ff <= '0;
                     in_sum_ff <= '0;
                     out_sum_ff <= '0;
                  end
                  default: ;
               endcase
            end
            SEQ_MIX: level_ff <= mix_level;
            SEQ_SCHED: begin
               if (auto_ff && tval_ff) begin
                  if (mode_ff == ST_OFF && cur_s >= on_at && day_ff < off_at) begin
                     begin_ff <= now_ff;
                     blevel_ff <= level_ff;
                     goal_ff <= max_lvl;
                     mode_ff <= ST_FADE_IN;
                  end else if (mode_ff == ST_ON && day_ff >= off_at) begin
                     begin_ff <= now_ff;
                     blevel_ff <= level_ff;
                     goal_ff <= '0;
                     mode_ff <= ST_FADE_OUT;
                  end
               end
            end
            default: ;
         endcase
      end
      if (seq_ff == SEQ_IDLE && req_valid) begin
         cmd_ff <= cmd_type'(req_cmd);
         now_ff <= req_now_ms;
         tval_ff <= req_time_valid;
         day_ff <= req_day_minute;
         sunset_ff <= req_sunset_minute;
         lreq_ff <= req_level_request;
      end
      if (seq_ff == SEQ_PCT && !running) pct_ff <= 7'd100;
      if (seq_ff == SEQ_DIVC) pct_ff <= div_q[6:0];
      if (seq_ff == SEQ_OUT && out_free) begin
         o_level_ff <= level_ff;
         o_pwm_ff <= pwm_prod[26:19];
         o_state_ff <= mode_ff;
         o_pct_ff <= pct_ff;
         o_cnt_ff <= on_cnt_ff;
         o_in_ff <= in_sum_ff;
         o_out_ff <= out_sum_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = o_level_ff;
   assign rsp_pwm_duty = o_pwm_ff;
   assign rsp_light_state = o_state_ff;
   assign rsp_fade_percent = o_pct_ff;
   assign rsp_cycle_count = o_cnt_ff;
   assign rsp_fade_in_total_ms = o_in_ff;
   assign rsp_fade_out_total_ms = o_out_ff;
endmodule

### hdl/slfc_div.sv
module slfc_div (
   input  logic                               clock,
   input  logic                               reset,
   input  slfc_pkg::div_cmd_type              cmd,
   input  logic [slfc_pkg::DurWidth-1:0]      divisor,
   output logic                               busy,
   output logic [slfc_pkg::QuotWidth-1:0]     quotient
);
   import slfc_pkg::*;

   logic [DurWidth-1:0]  rem_ff, rem_in;
   logic [QuotWidth-1:0] bits_ff, bits_in;
   logic [QuotWidth-1:0] quot_ff, quot_in;
   logic [StepWidth-1:0] cnt_ff, cnt_in;
   logic [DurWidth:0]    trial;
   logic                 fits;

   // one restoring step per cycle: remainder stays below the divisor
   assign trial = {rem_ff, bits_ff[QuotWidth-1]};
   assign fits = trial >= {1'b0, divisor};

   always_comb begin
      rem_in = rem_ff;
      bits_in = bits_ff;
      quot_in = quot_ff;
      cnt_in = cnt_ff;
      if (cmd.start) begin
         rem_in = cmd.rem;
         bits_in = cmd.bits;
         quot_in = '0;
         cnt_in = cmd.steps;
      end else if (cnt_ff != '0) begin
         rem_in = fits ? DurWidth'(trial - {1'b0, divisor}) : trial[DurWidth-1:0];
         bits_in = {bits_ff[QuotWidth-2:0], 1'b0};
         quot_in = {quot_ff[QuotWidth-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      bits_ff <= bits_in;
      quot_ff <= quot_in;
   end

   assign busy = cnt_ff != '0;
   assign quotient = quot_ff;
endmodule

### hdl/slfc_sine_rom.sv
module slfc_sine_rom #(
   parameter int SINE_INDEX_BITS = slfc_pkg::SineIndexBitsDefault
) (
   input  logic                       clock,
   input  logic [SINE_INDEX_BITS-1:0] addr,
   output logic [15:0]                data
);
   import slfc_pkg::*;

   localparam int Depth = 1 << SINE_INDEX_BITS;

   logic [15:0] tbl [Depth];
   logic [15:0] data_ff;

   for (genvar g = 0; g < Depth; g++) begin : g_tbl
      localparam logic [15:0] Val = sine_entry(g, SINE_INDEX_BITS);
      assign tbl[g] = Val;
   end

   always_ff @(posedge clock) begin
      data_ff <= tbl[addr];
   end

   assign data = data_ff;
endmodule

### hdl/slfc_checker.sv
`include "scheduled_light_fade_controller_unit_assert.svh"

module slfc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [6:0] rsp_level,
   input logic [6:0] rsp_fade_percent
);
   // an accepted item makes the block stall requests in the next cycle
   `SLFC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `SLFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `SLFC_ASSERT_NOW(a_level_range, clock, reset, rsp_valid, rsp_level <= 7'd100)
   `SLFC_ASSERT_NOW(a_pct_range, clock, reset, rsp_valid, rsp_fade_percent <= 7'd100)
endmodule

bind scheduled_light_fade_controller_unit slfc_checker u_slfc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_level        (rsp_level),
   .rsp_fade_percent (rsp_fade_percent)
);
